// ===== hdl/hhq_pkg.sv =====
package hhq_pkg;

    // default geometry
    localparam int GRID_SIDE_DEF    = 512;
    localparam int TERRAIN_SIZE_DEF = 1024;
    localparam int FRAC_BITS_DEF    = 10;

    // field widths
    localparam int STORE_AW   = 18;
    localparam int SAMPLE_W   = 16;
    localparam int COORD_W    = 16;
    localparam int HEIGHT_W   = 24;
    localparam int MAXH_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT = 2'd2;

    localparam logic [MAXH_W-1:0] MAX_HEIGHT_RST = 8'd100;

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // one item travelling down the pipeline
    typedef struct packed {
        logic                valid;
        logic                query;
        logic [STORE_AW-1:0] index;
        logic [SAMPLE_W-1:0] value;
    } t_item;

    // one result word leaving the datapath
    typedef struct packed {
        logic                valid;
        logic [HEIGHT_W-1:0] height;
        logic                in_range;
    } t_res;

    // bits of the fixed-point grid coordinate (cell and fraction)
    function automatic int quot_w(input int side, input int frac);
        return $clog2(((side - 1) << frac) + 1);
    endfunction

endpackage

// ===== hdl/hhq_intf.sv =====
interface hhq_in_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [hhq_pkg::STORE_AW-1:0]    sample_index;
    logic [hhq_pkg::SAMPLE_W-1:0]    sample_value;
    logic signed [hhq_pkg::COORD_W-1:0] world_x;
    logic signed [hhq_pkg::COORD_W-1:0] world_z;

    modport source (output valid, action, sample_index, sample_value, world_x, world_z,
                    input ready);
    modport sink (input valid, action, sample_index, sample_value, world_x, world_z,
                  output ready);
endinterface

interface hhq_out_if;
    logic                         valid;
    logic                         ready;
    logic [hhq_pkg::HEIGHT_W-1:0] height_q16;
    logic                         in_range;

    modport source (output valid, height_q16, in_range, input ready);
    modport sink (input valid, height_q16, in_range, output ready);
endinterface

interface hhq_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [hhq_pkg::CFG_IDX_W-1:0]  index;
    logic [hhq_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/hhq_ram.sv =====
module hhq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/hhq_map.sv =====
module hhq_map #(
    parameter int GRID_SIDE    = hhq_pkg::GRID_SIDE_DEF,
    parameter int TERRAIN_SIZE = hhq_pkg::TERRAIN_SIZE_DEF,
    parameter int FRAC_BITS    = hhq_pkg::FRAC_BITS_DEF,
    localparam int QW = hhq_pkg::quot_w(GRID_SIDE, FRAC_BITS)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  hhq_pkg::t_item                     i_item,
    input  logic signed [hhq_pkg::COORD_W-1:0] i_world_x,
    input  logic signed [hhq_pkg::COORD_W-1:0] i_world_z,
    input  logic signed [hhq_pkg::COORD_W-1:0] i_org_x,
    input  logic signed [hhq_pkg::COORD_W-1:0] i_org_z,
    output hhq_pkg::t_item                     o_item,
    output logic                               o_inr,
    output logic [QW-1:0]                      o_qx,
    output logic [QW-1:0]                      o_qz
);
    import hhq_pkg::*;

    localparam int NL = 2;                       // x lane, z lane
    localparam int NS = 2;                       // offset stage, scale stage
    localparam int OW = COORD_W + 1;
    localparam int SH = 2 * $clog2(TERRAIN_SIZE);
    localparam int XW = SH + QW + 1;
    // (side-1) * 2^frac / size as a fixed-point reciprocal, rounded up; since
    // 2^SH >= size^2 the floor is exact for every offset below the terrain size
    localparam longint        K_L   = longint'(GRID_SIDE - 1) << FRAC_BITS;
    localparam logic [XW-1:0] K_REC = XW'(((K_L << SH) + TERRAIN_SIZE - 1) / TERRAIN_SIZE);

    t_item                r_it  [NS];
    logic                 r_inr;
    logic signed [OW-1:0] r_off [NL];
    logic signed [OW-1:0] n_off [NL];
    logic [XW-1:0]        r_p   [NL];
    logic [XW-1:0]        n_p   [NL];
    logic                 n_ok  [NL];

    always_comb begin
        n_off[0] = {i_world_x[COORD_W-1], i_world_x} - {i_org_x[COORD_W-1], i_org_x};
        n_off[1] = {i_world_z[COORD_W-1], i_world_z} - {i_org_z[COORD_W-1], i_org_z};
        for (int l = 0; l < NL; l++) begin
            // inside the grid exactly when 0 <= offset < terrain size
            n_ok[l] = !r_off[l][OW-1] && ({1'b0, r_off[l][OW-2:0]} < OW'(TERRAIN_SIZE));
            // grid coordinate sits above bit SH of the scaled offset
            n_p[l]  = XW'(r_off[l][OW-2:0]) * K_REC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_it[s].valid <= 1'b0;
            end
        end else if (i_adv) begin
            r_it[0] <= i_item;
            for (int s = 1; s < NS; s++) begin
                r_it[s] <= r_it[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_inr <= n_ok[0] && n_ok[1];
            for (int l = 0; l < NL; l++) begin
                r_off[l] <= n_off[l];
                r_p[l]   <= n_p[l];
            end
        end
    end

    assign o_item = r_it[NS-1];
    assign o_inr  = r_inr;
    assign o_qx   = r_p[0][SH +: QW];
    assign o_qz   = r_p[1][SH +: QW];

endmodule

// ===== hdl/hhq_blend.sv =====
module hhq_blend #(
    parameter int GRID_SIDE = hhq_pkg::GRID_SIDE_DEF,
    parameter int FRAC_BITS = hhq_pkg::FRAC_BITS_DEF,
    localparam int QW = hhq_pkg::quot_w(GRID_SIDE, FRAC_BITS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  hhq_pkg::t_item              i_item,
    input  logic                        i_inr,
    input  logic [QW-1:0]               i_qx,
    input  logic [QW-1:0]               i_qz,
    input  logic [hhq_pkg::MAXH_W-1:0]  i_max_height,
    output hhq_pkg::t_res               o_res
);
    import hhq_pkg::*;

    localparam int GW = QW - FRAC_BITS;
    localparam int WW = FRAC_BITS + 1;
    localparam int PW = WW + SAMPLE_W;
    localparam int SW = PW + MAXH_W;
    localparam int NB = 4;
    localparam logic [WW-1:0]       ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [SW-1:0]       HALF = SW'(2 ** (FRAC_BITS - 1));
    localparam logic [STORE_AW-1:0] SIDE_A = STORE_AW'(GRID_SIDE);
    localparam logic [STORE_AW-1:0] ONE_A  = STORE_AW'(1);

    t_item               r_it  [NB];
    logic                r_inr [NB];
    logic [STORE_AW-1:0] r_base;
    logic                r_lower;
    logic [WW-1:0]       r_wa0, r_wb0, r_wc0, r_wa1, r_wb1, r_wc1;
    logic [PW-1:0]       r_pa, r_pb, r_pc, r_acc;

    logic [GW-1:0]        gx, gz;
    logic [FRAC_BITS-1:0] fx, fz;
    logic [WW-1:0]        fsum, n_wa, n_wb, n_wc;
    logic                 n_lower;
    logic [STORE_AW-1:0]  n_base, addr_a, addr_b, addr_c;
    logic [SAMPLE_W-1:0]  h_a, h_b, h_c;
    logic                 we;
    logic [SW-1:0]        scaled;

    // cell, fraction, triangle and barycentric weights
    always_comb begin
        gx   = i_qx[QW-1:FRAC_BITS];
        gz   = i_qz[QW-1:FRAC_BITS];
        fx   = i_qx[FRAC_BITS-1:0];
        fz   = i_qz[FRAC_BITS-1:0];
        fsum = WW'(fx) + WW'(fz);
        n_lower = (fsum <= ONE);
        // a: h10, b: h01, c: h00 (lower) or h11 (upper)
        n_wa = n_lower ? WW'(fx) : ONE - WW'(fz);
        n_wb = n_lower ? WW'(fz) : ONE - WW'(fx);
        n_wc = n_lower ? ONE - fsum : fsum - ONE;
        n_base = STORE_AW'(STORE_AW'(gz) * SIDE_A) + STORE_AW'(gx);
    end

    assign addr_a = r_base + ONE_A;
    assign addr_b = r_base + SIDE_A;
    assign addr_c = r_lower ? r_base : r_base + SIDE_A + ONE_A;
    assign we     = i_adv && r_it[0].valid && !r_it[0].query;

    // one copy of the store per corner role, all written alike
    hhq_ram #(.WIDTH(SAMPLE_W), .DEPTH(2 ** STORE_AW)) u_ram_a (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_it[0].index),
        .i_wdata(r_it[0].value),
        .i_re   (i_adv),
        .i_raddr(addr_a),
        .o_rdata(h_a)
    );

    hhq_ram #(.WIDTH(SAMPLE_W), .DEPTH(2 ** STORE_AW)) u_ram_b (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_it[0].index),
        .i_wdata(r_it[0].value),
        .i_re   (i_adv),
        .i_raddr(addr_b),
        .o_rdata(h_b)
    );

    hhq_ram #(.WIDTH(SAMPLE_W), .DEPTH(2 ** STORE_AW)) u_ram_c (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_it[0].index),
        .i_wdata(r_it[0].value),
        .i_re   (i_adv),
        .i_raddr(addr_c),
        .o_rdata(h_c)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NB; s++) begin
                r_it[s].valid <= 1'b0;
            end
        end else if (i_adv) begin
            r_it[0] <= i_item;
            for (int s = 1; s < NB; s++) begin
                r_it[s] <= r_it[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_inr[0] <= i_inr;
            for (int s = 1; s < NB; s++) begin
                r_inr[s] <= r_inr[s-1];
            end
            r_base  <= n_base;
            r_lower <= n_lower;
            r_wa0   <= n_wa;
            r_wb0   <= n_wb;
            r_wc0   <= n_wc;
            r_wa1   <= r_wa0;
            r_wb1   <= r_wb0;
            r_wc1   <= r_wc0;
            r_pa    <= PW'(r_wa1) * PW'(h_a);
            r_pb    <= PW'(r_wb1) * PW'(h_b);
            r_pc    <= PW'(r_wc1) * PW'(h_c);
            r_acc   <= r_pa + r_pb + r_pc;
        end
    end

    // scale by max height, round half up to 16 fraction bits
    assign scaled = SW'(r_acc) * SW'(i_max_height) + HALF;

    always_comb begin
        o_res.valid    = r_it[NB-1].valid && r_it[NB-1].query;
        o_res.in_range = r_inr[NB-1];
        o_res.height   = r_inr[NB-1] ? HEIGHT_W'(scaled >> FRAC_BITS) : '0;
    end

endmodule

// ===== hdl/heightfield_height_query.sv =====
// channel   dir  handshake      word
// i_in      in   valid/ready    action, sample_index, sample_value, world_x, world_z
// o_out     out  valid/ready    height_q16, in_range
// i_cfg     in   valid/ready    index (0 origin_x, 1 origin_z, 2 max_height), data
//
// one word per cycle in while i_in.ready is high; a write word gives no result, a query word gives one
// a query result reaches o_out through seven register stages:
// two for offset and scaling, four for store read and blend, one output register
// i_rst_n clears all valid bits, origins to 0 and max_height to 100; the store
// has no reset and must be written before it is queried
// a full skid register drops i_in.ready; the whole pipeline then holds in place
module heightfield_height_query #(
    parameter int GRID_SIDE    = hhq_pkg::GRID_SIDE_DEF,
    parameter int TERRAIN_SIZE = hhq_pkg::TERRAIN_SIZE_DEF,
    parameter int FRAC_BITS    = hhq_pkg::FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hhq_in_if.sink    i_in,
    hhq_out_if.source o_out,
    hhq_cfg_if.sink   i_cfg
);
    import hhq_pkg::*;

    localparam int QW = quot_w(GRID_SIDE, FRAC_BITS);

    // configuration registers
    logic signed [COORD_W-1:0] r_org_x;
    logic signed [COORD_W-1:0] r_org_z;
    logic [MAXH_W-1:0]         r_max_h;

    // output register and skid register
    t_res r_out;
    t_res r_skd;

    logic          adv;
    logic          out_fire;
    t_item         in_item;
    t_item         map_item;
    logic          map_inr;
    logic [QW-1:0] map_qx;
    logic [QW-1:0] map_qz;
    t_res          res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_z <= '0;
            r_max_h <= MAX_HEIGHT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ORIGIN_X:   r_org_x <= i_cfg.data;
                CFG_ORIGIN_Z:   r_org_z <= i_cfg.data;
                CFG_MAX_HEIGHT: r_max_h <= i_cfg.data[MAXH_W-1:0];
                default: ;      // unused index, ignored
            endcase
        end
    end

    // the pipeline moves whenever the skid register is free
    assign adv        = !r_skd.valid;
    assign i_in.ready = adv;
    assign out_fire   = r_out.valid && o_out.ready;

    always_comb begin
        in_item.valid = i_in.valid;
        in_item.query = (i_in.action == ACT_QUERY);
        in_item.index = i_in.sample_index;
        in_item.value = i_in.sample_value;
    end

    // offsets, range check, reciprocal scaling to cell plus fraction
    hhq_map #(
        .GRID_SIDE   (GRID_SIDE),
        .TERRAIN_SIZE(TERRAIN_SIZE),
        .FRAC_BITS   (FRAC_BITS)
    ) u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (in_item),
        .i_world_x(i_in.world_x),
        .i_world_z(i_in.world_z),
        .i_org_x  (r_org_x),
        .i_org_z  (r_org_z),
        .o_item   (map_item),
        .o_inr    (map_inr),
        .o_qx     (map_qx),
        .o_qz     (map_qz)
    );

    // store access in item order, corner fetch, weighting and scaling
    hhq_blend #(
        .GRID_SIDE(GRID_SIDE),
        .FRAC_BITS(FRAC_BITS)
    ) u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_item      (map_item),
        .i_inr       (map_inr),
        .i_qx        (map_qx),
        .i_qz        (map_qz),
        .i_max_height(r_max_h),
        .o_res       (res)
    );

    // result word lands in the output register, or in the skid register
    // when the output register is held by a stalled sink
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
            r_skd.valid <= 1'b0;
        end else if (adv) begin
            if (!r_out.valid || out_fire) begin
                r_out <= res;
            end else if (res.valid) begin
                r_skd <= res;
            end
        end else if (out_fire) begin
            r_out       <= r_skd;
            r_skd.valid <= 1'b0;
        end
    end

    assign o_out.valid      = r_out.valid;
    assign o_out.height_q16 = r_out.height;
    assign o_out.in_range   = r_out.in_range;

`ifndef NO_ASSERTIONS
    // the skid register only fills behind a held output word
    a_skd_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd.valid |-> r_out.valid)
        else $error("skid word without output word");

    // a draining skid word always moves into the output register
    a_skd_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd.valid && out_fire |=> r_out.valid && !r_skd.valid)
        else $error("skid word lost on drain");

    // no result word right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result word after reset");

    // a position outside the grid reports zero height
    a_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.in_range |-> o_out.height_q16 == '0)
        else $error("nonzero height outside grid");
`endif

endmodule
